@@ rtl/core/ale_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ale_pkg: array list engine package
// Operation codes, shift commands and shared constants.
// ----------------------------------------------------------------------------
package ale_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int OP_W         = 3;
  localparam int POS_W        = 5;
  localparam int VAL_W        = 32;
  localparam int FIDX_W       = 4;
  localparam int CNT_W        = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 3'd0,
    OP_DELETE   = 3'd1,
    OP_LOCATE   = 3'd2,
    OP_RETRIEVE = 3'd3,
    OP_SORTED   = 3'd4,
    OP_CLEAR    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    SH_HOLD = 2'd0,
    SH_INS  = 2'd1,
    SH_DEL  = 2'd2
  } shift_mode_t;

  typedef struct packed {
    shift_mode_t mode;
    logic        load_probe;
  } cell_cmd_t;

endpackage

@@ rtl/core/ale_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ale_cell: one list entry
// Holds one entry, shifts it up or down on insert and delete, and passes a
// probe copy toward entry zero during a scan.
// ----------------------------------------------------------------------------
module ale_cell #(
  parameter int INDEX = 0,
  parameter int LW    = 5
) (
  input  logic                        clk,
  input  ale_pkg::cell_cmd_t          cmd,
  input  logic [LW-1:0]               at,
  input  logic [ale_pkg::VAL_W-1:0]   ins_value,
  input  logic [ale_pkg::VAL_W-1:0]   left_data,
  input  logic [ale_pkg::VAL_W-1:0]   right_data,
  input  logic [ale_pkg::VAL_W-1:0]   right_probe,
  output logic [ale_pkg::VAL_W-1:0]   data,
  output logic [ale_pkg::VAL_W-1:0]   probe
);
  import ale_pkg::*;

  localparam logic [LW-1:0] IDX = LW'(INDEX);

  always_ff @(posedge clk) begin
    case (cmd.mode)
      SH_INS: begin
        if (IDX > at) begin
          data <= left_data;
        end else if (IDX == at) begin
          data <= ins_value;
        end
      end
      SH_DEL: begin
        if (IDX >= at) begin
          data <= right_data;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_probe) begin
      probe <= data;
    end else begin
      probe <= right_probe;
    end
  end

endmodule

@@ rtl/core/ale_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ale_ctrl: array list engine controller
// Decodes requests, keeps the entry count, drives the cell row and walks the
// probe chain for locate, retrieve and sorted insert.
// ----------------------------------------------------------------------------
module ale_ctrl #(
  parameter int CAPACITY = ale_pkg::CAPACITY_DEF,
  parameter int LW       = $clog2(CAPACITY + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ale_pkg::OP_W-1:0]           op,
  input  logic [ale_pkg::POS_W-1:0]          position,
  input  logic signed [ale_pkg::VAL_W-1:0]   value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               ok,
  output logic signed [ale_pkg::VAL_W-1:0]   read_value,
  output logic [ale_pkg::FIDX_W-1:0]         found_index,
  output logic [ale_pkg::CNT_W-1:0]          entry_count,
  input  logic [ale_pkg::VAL_W-1:0]          probe0,
  output ale_pkg::cell_cmd_t                 cmd,
  output logic [LW-1:0]                      at,
  output logic [ale_pkg::VAL_W-1:0]          ins_value
);
  import ale_pkg::*;

  localparam int CW = (LW > POS_W) ? LW : POS_W;
  localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t               state, state_next;
  logic [LW-1:0]        len, len_next;
  logic [LW-1:0]        cnt, cnt_next;
  logic [LW-1:0]        ipos, ipos_next;
  op_t                  op_q;
  logic [POS_W-1:0]     pos_q;
  logic [VAL_W-1:0]     key;
  logic                 accept;
  logic                 load_out;
  logic                 res_ok;
  logic [VAL_W-1:0]     res_rd;
  logic [LW-1:0]        res_fi;
  logic [CW-1:0]        pos_x, pos_qx, len_x, cnt_x;

  assign in_ready = !rst && (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign pos_x    = CW'(position);
  assign pos_qx   = CW'(pos_q);
  assign len_x    = CW'(len);
  assign cnt_x    = CW'(cnt);

  always_comb begin
    state_next     = state;
    len_next       = len;
    cnt_next       = cnt;
    ipos_next      = ipos;
    cmd.mode       = SH_HOLD;
    cmd.load_probe = 1'b0;
    at             = '0;
    ins_value      = value;
    load_out       = 1'b0;
    res_ok         = 1'b0;
    res_rd         = '0;
    res_fi         = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (op_t'(op))
            OP_INSERT: begin
              load_out = 1'b1;
              if (pos_x <= len_x && len < CAP_L) begin
                cmd.mode = SH_INS;
                at       = LW'(position);
                len_next = len + LW'(1);
                res_ok   = 1'b1;
              end
            end
            OP_DELETE: begin
              load_out = 1'b1;
              if (pos_x < len_x) begin
                cmd.mode = SH_DEL;
                at       = LW'(position);
                len_next = len - LW'(1);
                res_ok   = 1'b1;
              end
            end
            OP_LOCATE: begin
              cmd.load_probe = 1'b1;
              cnt_next       = '0;
              state_next     = ST_SCAN;
            end
            OP_RETRIEVE: begin
              if (pos_x < len_x) begin
                cmd.load_probe = 1'b1;
                cnt_next       = '0;
                state_next     = ST_SCAN;
              end else begin
                load_out = 1'b1;
              end
            end
            OP_SORTED: begin
              if (len < CAP_L) begin
                cmd.load_probe = 1'b1;
                cnt_next       = '0;
                ipos_next      = '0;
                state_next     = ST_SCAN;
              end else begin
                load_out = 1'b1;
              end
            end
            OP_CLEAR: begin
              load_out = 1'b1;
              len_next = '0;
              res_ok   = 1'b1;
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        ins_value = key;
        case (op_q)
          OP_LOCATE: begin
            if (cnt == len) begin
              load_out   = 1'b1;
              state_next = ST_IDLE;
            end else if (probe0 == key) begin
              load_out   = 1'b1;
              res_ok     = 1'b1;
              res_fi     = cnt;
              state_next = ST_IDLE;
            end else begin
              cnt_next = cnt + LW'(1);
            end
          end
          OP_RETRIEVE: begin
            if (cnt_x == pos_qx) begin
              load_out   = 1'b1;
              res_ok     = 1'b1;
              res_rd     = probe0;
              state_next = ST_IDLE;
            end else begin
              cnt_next = cnt + LW'(1);
            end
          end
          OP_SORTED: begin
            if (cnt == len) begin
              cmd.mode   = SH_INS;
              at         = ipos;
              len_next   = len + LW'(1);
              load_out   = 1'b1;
              res_ok     = 1'b1;
              state_next = ST_IDLE;
            end else begin
              if (!($signed(probe0) > $signed(key))) begin
                ipos_next = cnt + LW'(1);
              end
              cnt_next = cnt + LW'(1);
            end
          end
          default: begin
            load_out   = 1'b1;
            state_next = ST_IDLE;
          end
        endcase
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      len       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      len   <= len_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt  <= cnt_next;
    ipos <= ipos_next;
    if (accept) begin
      op_q  <= op_t'(op);
      pos_q <= position;
      key   <= value;
    end
    if (load_out) begin
      ok          <= res_ok;
      read_value  <= res_rd;
      found_index <= FIDX_W'(CW'(res_fi));
      entry_count <= CNT_W'(CW'(len_next));
    end
  end

endmodule

@@ rtl/core/array_list_engine_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_engine_core: fixed-capacity ordered list engine
// Usage:
//   Input channel (in_valid/in_ready) carries one request word: op, position,
//   value. Output channel (out_valid/out_ready) returns one result word per
//   request: ok, read_value, found_index, entry_count.
//   Entries live in a row of CAPACITY cells; insert and delete shift the
//   entries from the position upward on the accepting clock edge. Locate,
//   retrieve and sorted insert walk a probe copy of the row toward entry zero, one entry per cycle.
// Result path:
//   insert at, delete, clear, rejected requests: result registered in the
//   cycle after acceptance. Retrieve, locate and sorted insert load the probe
//   row, walk it in the scan state and register the result at the position,
//   the match or the count. The next request is taken once the controller is
//   idle and the result register is free or being emptied, so requests that
//   do not scan sustain one word per cycle while the receiver takes each result.
// Reset clears the internal entry count and the result valid flag; entry
// contents and the result word are left as they are. A stalled receiver
// holds the result word and blocks new requests until it is taken.
// ----------------------------------------------------------------------------
module array_list_engine_core #(
  parameter int CAPACITY = ale_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ale_pkg::OP_W-1:0]           op,
  input  logic [ale_pkg::POS_W-1:0]          position,
  input  logic signed [ale_pkg::VAL_W-1:0]   value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               ok,
  output logic signed [ale_pkg::VAL_W-1:0]   read_value,
  output logic [ale_pkg::FIDX_W-1:0]         found_index,
  output logic [ale_pkg::CNT_W-1:0]          entry_count
);
  import ale_pkg::*;

  localparam int LW = $clog2(CAPACITY + 1);

  cell_cmd_t           cmd;
  logic [LW-1:0]       at;
  logic [VAL_W-1:0]    ins_value;
  logic [VAL_W-1:0]    data  [CAPACITY];
  logic [VAL_W-1:0]    probe [CAPACITY];

  ale_ctrl #(
    .CAPACITY (CAPACITY),
    .LW       (LW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .position    (position),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .ok          (ok),
    .read_value  (read_value),
    .found_index (found_index),
    .entry_count (entry_count),
    .probe0      (probe[0]),
    .cmd         (cmd),
    .at          (at),
    .ins_value   (ins_value)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] left_d;
    logic [VAL_W-1:0] right_d;
    logic [VAL_W-1:0] right_p;

    if (i == 0) begin : g_first
      assign left_d = data[i];
    end else begin : g_mid_l
      assign left_d = data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_d = data[i];
      assign right_p = probe[i];
    end else begin : g_mid_r
      assign right_d = data[i+1];
      assign right_p = probe[i+1];
    end

    ale_cell #(
      .INDEX (i),
      .LW    (LW)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .at          (at),
      .ins_value   (ins_value),
      .left_data   (left_d),
      .right_data  (right_d),
      .right_probe (right_p),
      .data        (data[i]),
      .probe       (probe[i])
    );
  end

endmodule
